// ----- rtl/obb_sat_pkg.sv -----
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Shared types and widths for the oriented box separation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package obb_sat_pkg;

  localparam int CW = 34;   // corner coordinate, 1/65536 m
  localparam int NW = 27;   // edge normal component
  localparam int PW = 61;   // one coordinate product
  localparam int SW = 62;   // projection
  localparam int GW = 63;   // projection difference

  typedef logic [CW-1:0] crd_t;
  typedef logic [NW-1:0] nrm_t;
  typedef logic [SW-1:0] prj_t;

  typedef struct packed {
    logic [23:0] a_center_x;
    logic [23:0] a_center_y;
    logic [15:0] a_length;
    logic [15:0] a_width;
    logic [15:0] a_cos;
    logic [15:0] a_sin;
    logic [23:0] b_center_x;
    logic [23:0] b_center_y;
    logic [15:0] b_length;
    logic [15:0] b_width;
    logic [15:0] b_cos;
    logic [15:0] b_sin;
  } in_t;

  typedef struct packed {
    logic [45:0] separation;
    logic        overlap;
  } out_t;

  typedef struct packed {
    logic [23:0] center_x;
    logic [23:0] center_y;
    logic [15:0] length;
    logic [15:0] width;
    logic [15:0] cos_h;
    logic [15:0] sin_h;
  } box_t;

  typedef struct packed {
    crd_t [3:0] vx;
    crd_t [3:0] vy;
    nrm_t [3:0] nx;
    nrm_t [3:0] ny;
  } geo_t;

  typedef struct packed {
    prj_t amax;
    prj_t amin;
    prj_t bmax;
    prj_t bmin;
  } proj_t;

  // register load enables, one per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } stage_en_t;

endpackage
`default_nettype wire

// ----- rtl/obb_sat_corners.sv -----
// ----------------------------------------------------------------------------
// obb_sat_corners
// Stages 1-2: half-extent products, rounding, corners and edge normals.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_sat_corners (
  input  wire logic                   clk,
  input  wire obb_sat_pkg::stage_en_t en,
  input  wire obb_sat_pkg::box_t      box,
  output obb_sat_pkg::geo_t           geo
);
  import obb_sat_pkg::*;

  logic signed [32:0] ch_r, sw_r, sh_r, cw_r;
  logic        [23:0] cx_r, cy_r;
  geo_t               geo_r;

  function automatic logic signed [25:0] rnd(input logic signed [32:0] t);
    logic signed [32:0] u;
    u = t + 33'sd64;
    return u[32:7];
  endfunction

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ch_r <= $signed(box.cos_h) * $signed({1'b0, box.length});
      sw_r <= $signed(box.sin_h) * $signed({1'b0, box.width});
      sh_r <= $signed(box.sin_h) * $signed({1'b0, box.length});
      cw_r <= $signed(box.cos_h) * $signed({1'b0, box.width});
      cx_r <= box.center_x;
      cy_r <= box.center_y;
    end
  end

  logic signed [25:0] ch, sw, sh, cw;
  logic signed [CW-1:0] cx, cy, chx, swx, shx, cwx;
  logic signed [NW-1:0] ch2, sw2, sh2, cw2;
  geo_t geo_nxt;

  always_comb begin
    ch  = rnd(ch_r);
    sw  = rnd(sw_r);
    sh  = rnd(sh_r);
    cw  = rnd(cw_r);
    cx  = {{2{cx_r[23]}}, cx_r, 8'b0};
    cy  = {{2{cy_r[23]}}, cy_r, 8'b0};
    chx = {{8{ch[25]}}, ch};
    swx = {{8{sw[25]}}, sw};
    shx = {{8{sh[25]}}, sh};
    cwx = {{8{cw[25]}}, cw};
    ch2 = {ch, 1'b0};
    sw2 = {sw, 1'b0};
    sh2 = {sh, 1'b0};
    cw2 = {cw, 1'b0};
    geo_nxt.vx[0] = cx + chx - swx;
    geo_nxt.vy[0] = cy + shx + cwx;
    geo_nxt.vx[1] = cx + chx + swx;
    geo_nxt.vy[1] = cy + shx - cwx;
    geo_nxt.vx[2] = cx - chx + swx;
    geo_nxt.vy[2] = cy - shx - cwx;
    geo_nxt.vx[3] = cx - chx - swx;
    geo_nxt.vy[3] = cy - shx + cwx;
    // corner differences collapse to doubled terms
    geo_nxt.nx[0] = -cw2;
    geo_nxt.ny[0] = -sw2;
    geo_nxt.nx[1] = -sh2;
    geo_nxt.ny[1] = ch2;
    geo_nxt.nx[2] = cw2;
    geo_nxt.ny[2] = sw2;
    geo_nxt.nx[3] = sh2;
    geo_nxt.ny[3] = -ch2;
  end

  always_ff @(posedge clk) begin
    if (en.s2) geo_r <= geo_nxt;
  end

  assign geo = geo_r;

endmodule
`default_nettype wire

// ----- rtl/obb_sat_project.sv -----
// ----------------------------------------------------------------------------
// obb_sat_project
// Stages 3-5: projects both boxes onto one axis, keeps extremes per box.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_sat_project (
  input  wire logic                   clk,
  input  wire obb_sat_pkg::stage_en_t en,
  input  wire obb_sat_pkg::geo_t      ga,
  input  wire obb_sat_pkg::geo_t      gb,
  input  wire obb_sat_pkg::nrm_t      ax,
  input  wire obb_sat_pkg::nrm_t      ay,
  output obb_sat_pkg::proj_t          pj
);
  import obb_sat_pkg::*;

  logic signed [PW-1:0] px_r [8];
  logic signed [PW-1:0] py_r [8];
  logic signed [SW-1:0] p_r  [8];
  proj_t                pj_r;
  crd_t                 vx [8];
  crd_t                 vy [8];

  function automatic logic signed [SW-1:0] mx2(input logic signed [SW-1:0] a,
                                               input logic signed [SW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] mn2(input logic signed [SW-1:0] a,
                                               input logic signed [SW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vx[i]     = ga.vx[i];
      vy[i]     = ga.vy[i];
      vx[i + 4] = gb.vx[i];
      vy[i + 4] = gb.vy[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (en.s3) begin
        px_r[i] <= $signed(vx[i]) * $signed(ax);
        py_r[i] <= $signed(vy[i]) * $signed(ay);
      end
      if (en.s4) p_r[i] <= {px_r[i][PW-1], px_r[i]} + {py_r[i][PW-1], py_r[i]};
    end
    if (en.s5) begin
      pj_r.amax <= mx2(mx2(p_r[0], p_r[1]), mx2(p_r[2], p_r[3]));
      pj_r.amin <= mn2(mn2(p_r[0], p_r[1]), mn2(p_r[2], p_r[3]));
      pj_r.bmax <= mx2(mx2(p_r[4], p_r[5]), mx2(p_r[6], p_r[7]));
      pj_r.bmin <= mn2(mn2(p_r[4], p_r[5]), mn2(p_r[6], p_r[7]));
    end
  end

  assign pj = pj_r;

endmodule
`default_nettype wire

// ----- rtl/obb_sat_select.sv -----
// ----------------------------------------------------------------------------
// obb_sat_select
// Stages 6-7: per-axis gap test, then first separating axis wins.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_sat_select (
  input  wire logic                   clk,
  input  wire obb_sat_pkg::stage_en_t en,
  input  wire obb_sat_pkg::proj_t     pj [8],
  output obb_sat_pkg::out_t           res
);
  import obb_sat_pkg::*;

  logic [7:0]    flag_r;
  logic [SW-1:0] gap_r [8];
  out_t          res_r, res_nxt;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      logic signed [GW-1:0] d1, d2;
      d1 = {pj[k].bmin[SW-1], pj[k].bmin} - {pj[k].amax[SW-1], pj[k].amax};
      d2 = {pj[k].amin[SW-1], pj[k].amin} - {pj[k].bmax[SW-1], pj[k].bmax};
      if (en.s6) begin
        flag_r[k] <= (d1 > 0) || (d2 > 0);
        gap_r[k]  <= (d1 > 0) ? d1[SW-1:0] : d2[SW-1:0];
      end
    end
  end

  always_comb begin
    res_nxt.separation = '0;
    res_nxt.overlap    = 1'b1;
    // scan downward so the lowest separating axis is kept
    for (int k = 7; k >= 0; k--) begin
      if (flag_r[k]) begin
        res_nxt.separation = gap_r[k][SW-1:16];
        res_nxt.overlap    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s7) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ----- rtl/obb_separating_axis_gap.sv -----
// ----------------------------------------------------------------------------
// obb_separating_axis_gap
// Two-box separating axis test; returns the gap on the first separating
// edge normal (A's four, then B's four) or flags overlap.
//
// Input request: in_valid/in_ready with both boxes in in_data. Result
// request: out_valid/out_ready with separation and overlap in out_data.
// Seven register stages: products, corners, axis products, projections,
// extremes, gap test, selection. out_valid rises when the request is held
// in the selection stage; one request is accepted every cycle while in_ready
// is high.
// Every stage carries a valid bit and loads when it is empty or the stage
// after it moves, so a stalled receiver freezes only the occupied stages
// at the back and bubbles still close up; in_ready falls only when the
// whole pipe is full. Reset clears the valid bits; data registers do not
// reset. Nothing is lost or repeated under stall.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_separating_axis_gap (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire obb_sat_pkg::in_t  in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      obb_sat_pkg::out_t out_data
);
  import obb_sat_pkg::*;

  logic [7:1] v_r;
  logic [7:1] en_v;
  stage_en_t  en;
  box_t       box_a, box_b;
  geo_t       geo_a, geo_b;
  proj_t      pj [8];

  always_comb begin
    en_v[7] = ~v_r[7] | out_ready;
    for (int k = 6; k >= 1; k--) en_v[k] = ~v_r[k] | en_v[k + 1];
    en = '{s1: en_v[1], s2: en_v[2], s3: en_v[3], s4: en_v[4],
           s5: en_v[5], s6: en_v[6], s7: en_v[7]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en_v[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (en_v[k]) v_r[k] <= v_r[k - 1];
      end
    end
  end

  assign in_ready  = en_v[1];
  assign out_valid = v_r[7];

  assign box_a = '{center_x: in_data.a_center_x, center_y: in_data.a_center_y,
                   length: in_data.a_length, width: in_data.a_width,
                   cos_h: in_data.a_cos, sin_h: in_data.a_sin};
  assign box_b = '{center_x: in_data.b_center_x, center_y: in_data.b_center_y,
                   length: in_data.b_length, width: in_data.b_width,
                   cos_h: in_data.b_cos, sin_h: in_data.b_sin};

  obb_sat_corners u_corners_a (.clk(clk), .en(en), .box(box_a), .geo(geo_a));
  obb_sat_corners u_corners_b (.clk(clk), .en(en), .box(box_b), .geo(geo_b));

  for (genvar k = 0; k < 8; k++) begin : g_axis
    obb_sat_project u_project (
      .clk(clk),
      .en (en),
      .ga (geo_a),
      .gb (geo_b),
      .ax ((k < 4) ? geo_a.nx[k % 4] : geo_b.nx[k % 4]),
      .ay ((k < 4) ? geo_a.ny[k % 4] : geo_b.ny[k % 4]),
      .pj (pj[k])
    );
  end

  obb_sat_select u_select (.clk(clk), .en(en), .pj(pj), .res(out_data));

endmodule
`default_nettype wire
